// ----- src/ash_frame_encoder_unit_defines.svh -----
// assertion macros for the ash frame encoder checker
`ifndef ASH_FRAME_ENCODER_UNIT_DEFINES_SVH
`define ASH_FRAME_ENCODER_UNIT_DEFINES_SVH

// same-cycle implication, quiet while reset is asserted
`define AFE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, quiet while reset is asserted
`define AFE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/afe_pkg.sv -----
`default_nettype none

package afe_pkg;

	// frame and crc constants
	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'h1021;
	localparam logic [7:0]  LFSR_INIT  = 8'h42;
	localparam logic [7:0]  LFSR_TAPS  = 8'hB8;
	localparam logic [7:0]  ESC_BYTE   = 8'h7D;
	localparam logic [7:0]  FLAG_BYTE  = 8'h7E;
	localparam logic [7:0]  ESC_FLIP   = 8'h20;
	localparam logic [7:0]  XON_BYTE   = 8'h11;
	localparam logic [7:0]  XOFF_BYTE  = 8'h13;
	localparam logic [7:0]  CAN_BYTE   = 8'h18;
	localparam logic [7:0]  SUB_BYTE   = 8'h1A;

	// msb-first crc-16-ccitt over one byte, no final xor
	function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (r[15]) begin
				r = {r[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				r = {r[14:0], 1'b0};
			end
		end
		return r;
	endfunction

	// right-shift lfsr step
	function automatic logic [7:0] lfsr_step(input logic [7:0] s);
		logic [7:0] n;
		n = {1'b0, s[7:1]};
		if (s[0]) begin
			n = n ^ LFSR_TAPS;
		end
		return n;
	endfunction

	// reserved wire bytes that go out as escape plus flipped byte
	function automatic logic needs_escape(input logic [7:0] b);
		return (b == XON_BYTE) || (b == XOFF_BYTE) || (b == CAN_BYTE) ||
			(b == SUB_BYTE) || (b == ESC_BYTE) || (b == FLAG_BYTE);
	endfunction

endpackage

`default_nettype wire

// ----- src/ash_frame_encoder_unit.sv -----
// channel   signals                                             direction
// data      data_valid, data_ready, data_byte, frame_last       into the block
// result    result_valid, result_ready, out_byte, run_last      out of the block
//
// Each data transaction gives 1 to 7 result transactions, one per cycle
// from the output register; the job register feeds it one wire byte a cycle.
// A byte that needs no escape and is not the last of a frame is one wire byte,
// so a new data transaction can be taken in every such cycle. arst_n clears
// the frame state (start-of-frame flag, lfsr 0x42, crc 0xFFFF). A stall on
// result holds the output register and the job; data_ready drops until the
// job in hand has sent its final byte.
`default_nettype none

module ash_frame_encoder_unit (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       data_valid,
	output logic            data_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       frame_last,
	output logic            result_valid,
	input  wire logic       result_ready,
	output logic [7:0]      out_byte,
	output logic            run_last
);

	typedef enum logic [1:0] {
		UNIT_DATA,
		UNIT_CRC_HI,
		UNIT_CRC_LO,
		UNIT_FLAG
	} unit_t;

	// frame state
	logic        at_start_q;
	logic [7:0]  lfsr_q;
	logic [15:0] crc_q;

	// job register, one accepted byte with its trailer
	logic        job_valid_s1;
	logic [7:0]  job_data_s1;
	logic [15:0] job_crc_s1;
	logic        job_last_s1;
	unit_t       unit_q;
	logic        esc_q;

	// output register
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        run_last_q;

	logic        accept;
	logic [7:0]  scr_byte;
	logic [15:0] crc_next;
	logic [7:0]  cur_byte;
	logic        esc_need;
	logic        prefix;
	logic        final_byte;
	logic        emit;
	logic [7:0]  emit_byte;

	// randomize the incoming byte (not a frame's first) and update crc over it
	always_comb begin
		scr_byte = at_start_q ? data_byte : (data_byte ^ lfsr_q);
		crc_next = afe_pkg::crc_byte(crc_q, scr_byte);
	end

	// pick the byte of the current unit
	always_comb begin
		case (unit_q)
			UNIT_DATA:   cur_byte = job_data_s1;
			UNIT_CRC_HI: cur_byte = job_crc_s1[15:8];
			UNIT_CRC_LO: cur_byte = job_crc_s1[7:0];
			default:     cur_byte = afe_pkg::FLAG_BYTE;
		endcase
	end

	// stuffing and sequencing of the job
	always_comb begin
		esc_need   = (unit_q != UNIT_FLAG) && afe_pkg::needs_escape(cur_byte);
		prefix     = esc_need && !esc_q;
		final_byte = !prefix && ((unit_q == UNIT_FLAG) ||
			((unit_q == UNIT_DATA) && !job_last_s1));
		emit       = job_valid_s1 && (!out_valid_q || result_ready);
		if (prefix) begin
			emit_byte = afe_pkg::ESC_BYTE;
		end else if (esc_need) begin
			emit_byte = cur_byte ^ afe_pkg::ESC_FLIP;
		end else begin
			emit_byte = cur_byte;
		end
		data_ready = !job_valid_s1 || (emit && final_byte);
		accept     = data_valid && data_ready;
	end

	// frame state, back to reset values after the last byte of a frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_start_q <= 1'b1;
			lfsr_q     <= afe_pkg::LFSR_INIT;
			crc_q      <= afe_pkg::CRC_INIT;
		end else if (accept) begin
			if (frame_last) begin
				at_start_q <= 1'b1;
				lfsr_q     <= afe_pkg::LFSR_INIT;
				crc_q      <= afe_pkg::CRC_INIT;
			end else begin
				at_start_q <= 1'b0;
				crc_q      <= crc_next;
				if (!at_start_q) begin
					lfsr_q <= afe_pkg::lfsr_step(lfsr_q);
				end
			end
		end
	end

	// job control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_s1 <= 1'b0;
			unit_q       <= UNIT_DATA;
			esc_q        <= 1'b0;
		end else if (accept) begin
			job_valid_s1 <= 1'b1;
			unit_q       <= UNIT_DATA;
			esc_q        <= 1'b0;
		end else if (emit) begin
			if (final_byte) begin
				job_valid_s1 <= 1'b0;
			end else if (prefix) begin
				esc_q <= 1'b1;
			end else begin
				esc_q  <= 1'b0;
				unit_q <= unit_t'(unit_q + 2'd1);
			end
		end
	end

	// job payload
	always_ff @(posedge clk) begin
		if (accept) begin
			job_data_s1 <= scr_byte;
			job_crc_s1  <= crc_next;
			job_last_s1 <= frame_last;
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= emit_byte;
			run_last_q <= final_byte;
		end
	end

	assign result_valid = out_valid_q;
	assign out_byte     = out_byte_q;
	assign run_last     = run_last_q;

endmodule

`default_nettype wire

// ----- src/ash_frame_encoder_unit_checker.sv -----
`default_nettype none
`include "ash_frame_encoder_unit_defines.svh"

module afe_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       result_valid,
	input wire logic       result_ready,
	input wire logic [7:0] out_byte,
	input wire logic       run_last
);

	// a stalled result transaction holds
	`AFE_ASSERT_NEXT(a_hold, result_valid && !result_ready, result_valid && $stable(out_byte) && $stable(run_last), "result changed while stalled")

	// an escape byte is never marked last, so its flipped byte follows in the run
	`AFE_ASSERT_NOW(a_esc_not_last, result_valid && out_byte == afe_pkg::ESC_BYTE, !run_last, "escape byte marked last")

	// a bare flag byte is always marked as the last byte of its run
	`AFE_ASSERT_NOW(a_flag_last, result_valid && out_byte == afe_pkg::FLAG_BYTE, run_last, "flag byte not marked last")

	// the rest of a run follows without a gap
	`AFE_ASSERT_NEXT(a_run_gapless, result_valid && result_ready && !run_last, result_valid, "gap inside a run")

endmodule

bind ash_frame_encoder_unit afe_checker u_afe_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.out_byte     (out_byte),
	.run_last     (run_last)
);

`default_nettype wire
